### rtl/sts_pkg.sv
// shared types, codes and constants of the sorted time / set point table
`default_nettype none

package sts_pkg;

	// default number of entries in the table
	localparam int DEFAULT_DEPTH = 16;

	// fixed field widths
	localparam int TIME_W = 8;
	localparam int SP_W   = 8;
	localparam int POS_W  = 8;
	localparam int OUT_W  = 9;

	// value reported when a result field carries nothing
	localparam logic signed [OUT_W-1:0] NONE_VAL = 9'h1FF;

	// request codes
	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_REMOVE  = 3'd1,
		OP_LOOKUP  = 3'd2,
		OP_INDEXOF = 3'd3,
		OP_GETAT   = 3'd4,
		OP_CLEAR   = 3'd5
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_OVERWRITE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// control state of the sequencer
	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// latched request
	typedef struct packed {
		logic [2:0]        req_type;
		logic [TIME_W-1:0] key_time;
		logic [SP_W-1:0]   set_point;
		logic [POS_W-1:0]  position;
		logic signed [1:0] search_mode;
	} req_t;

	// command broadcast to every cell
	typedef struct packed {
		logic              ins;
		logic              ovr;
		logic              rem;
		logic [TIME_W-1:0] key_time;
		logic [SP_W-1:0]   set_point;
	} cmd_t;

	// compare flags reported by every cell
	typedef struct packed {
		logic lt;
		logic eq;
		logic ins;
	} flag_t;

endpackage

`default_nettype wire

### rtl/sts_if.sv
// request and result channel interfaces of the sorted time / set point table
`default_nettype none

interface sts_req_if;
	import sts_pkg::*;

	logic              valid;
	logic              ready;
	logic [2:0]        req_type;
	logic [TIME_W-1:0] key_time;
	logic [SP_W-1:0]   set_point;
	logic [POS_W-1:0]  position;
	logic signed [1:0] search_mode;

	modport source (output valid, req_type, key_time, set_point, position, search_mode,
		input ready);
	modport sink (input valid, req_type, key_time, set_point, position, search_mode,
		output ready);
endinterface

interface sts_rsp_if;
	import sts_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic signed [OUT_W-1:0] result_position;
	logic signed [OUT_W-1:0] result_time;
	logic signed [OUT_W-1:0] result_set_point;
	logic [OUT_W-1:0]        entry_count_out;

	modport source (output valid, status, result_position, result_time, result_set_point,
		entry_count_out, input ready);
	modport sink (input valid, status, result_position, result_time, result_set_point,
		entry_count_out, output ready);
endinterface

`default_nettype wire

### rtl/sts_cell.sv
// one table entry: holds a pair, compares it to the key and shifts with its neighbors
`default_nettype none

module sts_cell (
	input  wire logic                       clk,
	input  wire logic                       valid,
	input  wire sts_pkg::cmd_t              cmd,
	input  wire logic                       lt_left,
	input  wire logic [sts_pkg::TIME_W-1:0] left_time,
	input  wire logic [sts_pkg::SP_W-1:0]   left_sp,
	input  wire logic [sts_pkg::TIME_W-1:0] right_time,
	input  wire logic [sts_pkg::SP_W-1:0]   right_sp,
	output sts_pkg::flag_t                  flags,
	output logic [sts_pkg::TIME_W-1:0]      cell_time,
	output logic [sts_pkg::SP_W-1:0]        cell_sp
);
	import sts_pkg::*;

	logic [TIME_W-1:0] time_q;
	logic [SP_W-1:0]   sp_q;

	// compare against the broadcast key; the insert point is the first cell not below it
	always_comb begin
		flags.lt  = valid && (time_q < cmd.key_time);
		flags.eq  = valid && (time_q == cmd.key_time);
		flags.ins = !flags.lt && lt_left;
	end

	// insert shifts up from the insert point, remove shifts down from the match
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (flags.ins) begin
				time_q <= cmd.key_time;
				sp_q   <= cmd.set_point;
			end else if (!flags.lt) begin
				time_q <= left_time;
				sp_q   <= left_sp;
			end
		end else if (cmd.rem && !flags.lt) begin
			time_q <= right_time;
			sp_q   <= right_sp;
		end else if (cmd.ovr && flags.eq) begin
			sp_q <= cmd.set_point;
		end
	end

	assign cell_time = time_q;
	assign cell_sp   = sp_q;

endmodule

`default_nettype wire

### rtl/sorted_time_setpoint_table.sv
// top level of the sorted time / set point table
`default_nettype none

// Sorted table of up to DEPTH (time, set point) byte pairs kept in ascending time order.
// Each request is accepted in the idle state, then moves to the execute state in which
// every cell of the chain compares its entry with the key and, for add or remove,
// the whole row shifts by one place at once. The result sits in an output register, so
// a new request is accepted while the previous result waits; the execute state of that
// request holds until the output register is free. The stores need no clearing pass
// after reset: only entries below the entry count are ever read.
module sorted_time_setpoint_table #(
	parameter int DEPTH = sts_pkg::DEFAULT_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sts_req_if.sink   req,
	sts_rsp_if.source rsp
);
	import sts_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;
	req_t   req_q;
	logic   exec_fire;
	logic   out_free;

	logic [CW-1:0] count_q, count_d;

	cmd_t              cmd;
	flag_t             flag_w [DEPTH];
	logic [TIME_W-1:0] time_w [DEPTH];
	logic [SP_W-1:0]   sp_w   [DEPTH];
	logic [DEPTH-1:0]  cell_valid;
	logic [DEPTH-1:0]  ins_vec;
	logic [DEPTH-1:0]  eq_vec;

	logic              found, any_ins, at_idx_valid, hit;
	logic [CW-1:0]     idx_or, idx, idx_m1;
	logic [SP_W-1:0]   sp_eq, sp_sel;
	logic [TIME_W-1:0] time_sel;
	logic              full, mode_pos, mode_neg;

	status_t                 status_d;
	logic signed [OUT_W-1:0] rpos_d, rtime_d, rsp_d;

	logic                    rsp_valid_q;
	status_t                 status_q;
	logic signed [OUT_W-1:0] rpos_q, rtime_q, rsp_q;
	logic [OUT_W-1:0]        count_out_q;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		exec_fire = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					exec_fire = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// latch the accepted request
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q.req_type    <= req.req_type;
			req_q.key_time    <= req.key_time;
			req_q.set_point   <= req.set_point;
			req_q.position    <= req.position;
			req_q.search_mode <= req.search_mode;
		end
	end

	// the row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic              lt_left;
		logic [TIME_W-1:0] left_time, right_time;
		logic [SP_W-1:0]   left_sp, right_sp;

		if (i == 0) begin : g_first
			assign lt_left   = 1'b1;
			assign left_time = '0;
			assign left_sp   = '0;
		end else begin : g_mid
			assign lt_left   = flag_w[i-1].lt;
			assign left_time = time_w[i-1];
			assign left_sp   = sp_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_time = '0;
			assign right_sp   = '0;
		end else begin : g_inner
			assign right_time = time_w[i+1];
			assign right_sp   = sp_w[i+1];
		end

		assign cell_valid[i] = CW'(i) < count_q;
		assign ins_vec[i]    = flag_w[i].ins;
		assign eq_vec[i]     = flag_w[i].eq;

		sts_cell u_cell (
			.clk        (clk),
			.valid      (cell_valid[i]),
			.cmd        (cmd),
			.lt_left    (lt_left),
			.left_time  (left_time),
			.left_sp    (left_sp),
			.right_time (right_time),
			.right_sp   (right_sp),
			.flags      (flag_w[i]),
			.cell_time  (time_w[i]),
			.cell_sp    (sp_w[i])
		);
	end

	// gather match, insert point and selected entry across the row
	always_comb begin
		found        = 1'b0;
		any_ins      = 1'b0;
		at_idx_valid = 1'b0;
		hit          = 1'b0;
		idx_or       = '0;
		sp_eq        = '0;
		sp_sel       = '0;
		time_sel     = '0;
		for (int i = 0; i < DEPTH; i++) begin
			found        = found | flag_w[i].eq;
			any_ins      = any_ins | flag_w[i].ins;
			at_idx_valid = at_idx_valid | (flag_w[i].ins & cell_valid[i]);
			if (flag_w[i].ins) begin
				idx_or = idx_or | CW'(i);
			end
			if (flag_w[i].eq) begin
				sp_eq = sp_eq | sp_w[i];
			end
			if (cell_valid[i] && (req_q.position == POS_W'(i))) begin
				hit      = 1'b1;
				sp_sel   = sp_sel | sp_w[i];
				time_sel = time_sel | time_w[i];
			end
		end
	end

	assign idx      = any_ins ? idx_or : CW'(DEPTH);
	assign idx_m1   = idx - CW'(1);
	assign full     = (count_q == CW'(DEPTH));
	assign mode_pos = (req_q.search_mode == 2'sb01);
	assign mode_neg = req_q.search_mode[1];

	// command to the cells, only in the cycle the request completes
	always_comb begin
		cmd.key_time  = req_q.key_time;
		cmd.set_point = req_q.set_point;
		cmd.ins = exec_fire && (req_q.req_type == OP_ADD) && !found && !full;
		cmd.ovr = exec_fire && (req_q.req_type == OP_ADD) && found;
		cmd.rem = exec_fire && (req_q.req_type == OP_REMOVE) && found;
	end

	// result and new count
	always_comb begin
		status_d = ST_NOT_FOUND;
		rpos_d   = NONE_VAL;
		rtime_d  = NONE_VAL;
		rsp_d    = NONE_VAL;
		count_d  = count_q;
		case (req_q.req_type)
			OP_ADD: begin
				if (found) begin
					status_d = ST_OVERWRITE;
					rpos_d   = OUT_W'(idx);
				end else if (!full) begin
					status_d = ST_DONE;
					rpos_d   = OUT_W'(idx);
					count_d  = count_q + CW'(1);
				end else begin
					status_d = ST_FULL;
				end
			end
			OP_REMOVE: begin
				if (found) begin
					status_d = ST_DONE;
					rpos_d   = OUT_W'(idx);
					count_d  = count_q - CW'(1);
				end
			end
			OP_LOOKUP: begin
				if (found) begin
					status_d = ST_DONE;
					rpos_d   = OUT_W'(idx);
					rsp_d    = OUT_W'(sp_eq);
				end
			end
			OP_INDEXOF: begin
				if (found || (mode_pos && at_idx_valid)) begin
					status_d = ST_DONE;
					rpos_d   = OUT_W'(idx);
				end else if (mode_neg && (idx != '0)) begin
					status_d = ST_DONE;
					rpos_d   = OUT_W'(idx_m1);
				end
			end
			OP_GETAT: begin
				if (hit) begin
					status_d = ST_DONE;
					rpos_d   = OUT_W'(req_q.position);
					rtime_d  = OUT_W'(time_sel);
					rsp_d    = OUT_W'(sp_sel);
				end
			end
			OP_CLEAR: begin
				status_d = ST_DONE;
				count_d  = '0;
			end
			default: begin
				status_d = ST_NOT_FOUND;
			end
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (exec_fire) begin
			count_q <= count_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (exec_fire) begin
			status_q    <= status_d;
			rpos_q      <= rpos_d;
			rtime_q     <= rtime_d;
			rsp_q       <= rsp_d;
			count_out_q <= OUT_W'(count_d);
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = status_q;
	assign rsp.result_position  = rpos_q;
	assign rsp.result_time      = rtime_q;
	assign rsp.result_set_point = rsp_q;
	assign rsp.entry_count_out  = count_out_q;

	// the count never passes the table depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond table depth");

	// entries stay unique, so at most one cell matches a key
	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |-> $onehot0(eq_vec))
		else $error("more than one entry matches the key");

	// the row is sorted, so there is at most one insert point
	a_one_insert: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |-> $onehot0(ins_vec))
		else $error("more than one insert point in the row");

	// a completed request always leaves a result behind
	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |=> rsp_valid_q)
		else $error("completed request left no result");

endmodule

`default_nettype wire

### tb/sv/sorted_time_setpoint_table_tb.sv
// testbench for the sorted time / set point table: directed and random requests with a scoreboard
`default_nettype none

module sorted_time_setpoint_table_tb;
	import sts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = DEFAULT_DEPTH;
	localparam int RANDOM_ITEMS = 600;
	localparam int IDLE_LIMIT   = 1000;
	localparam int HOLD_CYCLES  = 80;
	localparam int SETTLE       = 10;

	// request codes the block ignores
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;

	// search modes for index of
	localparam logic signed [1:0] MODE_EXACT     = 2'sb00;
	localparam logic signed [1:0] MODE_HIGHER    = 2'sb01;
	localparam logic signed [1:0] MODE_LOWER     = 2'sb11;
	localparam logic signed [1:0] MODE_LOWER_ALT = 2'sb10;

	typedef struct packed {
		logic [2:0]        op;
		logic [7:0]        key;
		logic [7:0]        sp;
		logic [7:0]        pos;
		logic signed [1:0] mode;
	} request_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [OUT_W-1:0] position;
		logic signed [OUT_W-1:0] time_val;
		logic signed [OUT_W-1:0] sp_val;
		logic [OUT_W-1:0]        count;
	} table_result_t;

	// shadow table and queue of expected results
	class table_checker;
		logic [7:0]    time_tab[DEPTH];
		logic [7:0]    sp_tab[DEPTH];
		int            count;
		table_result_t expected_results[$];
		int            failures;

		function new();
			count = 0;
			failures = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// update the shadow table and queue the result this request should give
		function void note_request(request_t r);
			table_result_t e;
			int            idx;
			bit            hit;
			e.status   = ST_NOT_FOUND;
			e.position = NONE_VAL;
			e.time_val = NONE_VAL;
			e.sp_val   = NONE_VAL;
			idx = 0;
			while (idx < count && time_tab[idx] < r.key)
				idx++;
			hit = (idx < count) && (time_tab[idx] == r.key);
			case (r.op)
				OP_ADD: begin
					if (hit) begin
						sp_tab[idx] = r.sp;
						e.status = ST_OVERWRITE;
						e.position = OUT_W'(idx);
					end else if (count < DEPTH) begin
						for (int i = count; i > idx; i--) begin
							time_tab[i] = time_tab[i-1];
							sp_tab[i] = sp_tab[i-1];
						end
						time_tab[idx] = r.key;
						sp_tab[idx] = r.sp;
						count++;
						e.status = ST_DONE;
						e.position = OUT_W'(idx);
					end else begin
						e.status = ST_FULL;
					end
				end
				OP_REMOVE: begin
					if (hit) begin
						for (int i = idx; i + 1 < count; i++) begin
							time_tab[i] = time_tab[i+1];
							sp_tab[i] = sp_tab[i+1];
						end
						count--;
						e.status = ST_DONE;
						e.position = OUT_W'(idx);
					end
				end
				OP_LOOKUP: begin
					if (hit) begin
						e.status = ST_DONE;
						e.position = OUT_W'(idx);
						e.sp_val = OUT_W'(sp_tab[idx]);
					end
				end
				OP_INDEXOF: begin
					// exact first, then next higher or next lower by mode
					if (count > 0) begin
						if (hit || (r.mode == MODE_HIGHER && idx < count)) begin
							e.status = ST_DONE;
							e.position = OUT_W'(idx);
						end else if (r.mode[1] && idx > 0) begin
							e.status = ST_DONE;
							e.position = OUT_W'(idx - 1);
						end
					end
				end
				OP_GETAT: begin
					if (int'(r.pos) < count) begin
						e.status = ST_DONE;
						e.position = OUT_W'(r.pos);
						e.time_val = OUT_W'(time_tab[r.pos]);
						e.sp_val = OUT_W'(sp_tab[r.pos]);
					end
				end
				OP_CLEAR: begin
					count = 0;
					e.status = ST_DONE;
				end
				default: ;
			endcase
			e.count = OUT_W'(count);
			expected_results.push_back(e);
		endfunction

		// compare one result against the oldest expectation
		function void check_result(table_result_t got);
			table_result_t e;
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result with no request pending: status=%0d pos=%0d",
						$realtime, got.status, got.position);
				return;
			end
			e = expected_results.pop_front();
			if (got.status !== e.status || got.position !== e.position ||
					got.time_val !== e.time_val || got.sp_val !== e.sp_val ||
					got.count !== e.count) begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: mismatch exp status=%0d pos=%0d time=%0d sp=%0d count=%0d",
						$realtime, e.status, e.position, e.time_val, e.sp_val, e.count);
					$display("%0t:          got status=%0d pos=%0d time=%0d sp=%0d count=%0d",
						$realtime, got.status, got.position, got.time_val, got.sp_val,
						got.count);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sts_req_if req_ch ();
	sts_rsp_if rsp_ch ();

	sorted_time_setpoint_table #(.DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	table_checker checker_q = new();

	bit hold_off_req = 1'b0;
	int idle_count   = 0;
	int burst_left   = 0;
	bit gaps_on      = 1'b1;
	int pressure_items = 0;

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// accepted requests feed the predictor, accepted results are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				checker_q.note_request('{req_ch.req_type, req_ch.key_time, req_ch.set_point,
					req_ch.position, req_ch.search_mode});
			if (rsp_ch.valid && rsp_ch.ready)
				checker_q.check_result('{rsp_ch.status, rsp_ch.result_position,
					rsp_ch.result_time, rsp_ch.result_set_point, rsp_ch.entry_count_out});
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_count <= 0;
			else
				idle_count <= idle_count + 1;
			if (idle_count >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// result side: stall pattern redrawn at random, long hold-off on request
	initial begin
		int cyc;
		int hold_left;
		int pattern;
		cyc = 0;
		hold_left = 0;
		pattern = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 64 == 0)
				pattern = $urandom_range(0, 2);
			if (hold_left == 0 && hold_off_req) begin
				hold_left = HOLD_CYCLES;
				hold_off_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready = 1'b0;
			end else begin
				case (pattern)
					0: rsp_ch.ready = 1'b1;
					1: rsp_ch.ready = ($urandom_range(0, 2) != 0);
					default: rsp_ch.ready = (cyc % 5 < 3);
				endcase
			end
		end
	end

	function automatic request_t mk(logic [2:0] op, logic [7:0] key, logic [7:0] sp,
			logic [7:0] pos, logic signed [1:0] mode);
		mk = '{op, key, sp, pos, mode};
	endfunction

	// drive one request and hold it until accepted
	task automatic send_request(request_t r);
		@(negedge clk);
		req_ch.valid       = 1'b1;
		req_ch.req_type    = r.op;
		req_ch.key_time    = r.key;
		req_ch.set_point   = r.sp;
		req_ch.position    = r.pos;
		req_ch.search_mode = r.mode;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
		end
	endtask

	// send in bursts with random gaps between them
	task automatic send_paced(request_t r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on && pressure_items == 0)
				idle_cycles($urandom_range(1, 6));
		end
		burst_left--;
		if (pressure_items > 0)
			pressure_items--;
		send_request(r);
	endtask

	// mostly a small pool of times so entries collide, sometimes the full range
	function automatic logic [7:0] rand_key();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 47));
	endfunction

	function automatic logic [7:0] rand_pos();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, DEPTH + 1));
	endfunction

	function automatic request_t rand_mixed();
		int       w;
		request_t r;
		w = $urandom_range(0, 99);
		r = mk(OP_ADD, rand_key(), 8'($urandom), rand_pos(), 2'($urandom));
		if (w < 28)
			r.op = OP_ADD;
		else if (w < 48)
			r.op = OP_REMOVE;
		else if (w < 66)
			r.op = OP_LOOKUP;
		else if (w < 83)
			r.op = OP_INDEXOF;
		else if (w < 98)
			r.op = OP_GETAT;
		else
			r.op = OP_CLEAR;
		return r;
	endfunction

	// main stimulus
	initial begin
		int       sent;
		int       kind;
		int       n;
		int       pressure_step;
		request_t r;
		sent = 0;
		pressure_step = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = OP_ADD;
		req_ch.key_time = '0;
		req_ch.set_point = '0;
		req_ch.position = '0;
		req_ch.search_mode = MODE_EXACT;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, extremes, overwrite, search modes, get at bounds
		send_request(mk(OP_LOOKUP, 8'd5, 8'd0, 8'd0, MODE_EXACT));
		send_request(mk(OP_INDEXOF, 8'd5, 8'd0, 8'd0, MODE_HIGHER));
		send_request(mk(OP_GETAT, 8'd0, 8'd0, 8'd0, MODE_EXACT));
		send_request(mk(OP_REMOVE, 8'd5, 8'd0, 8'd0, MODE_EXACT));
		send_request(mk(OP_ADD, 8'd128, 8'h55, 8'd0, MODE_EXACT));
		send_request(mk(OP_ADD, 8'd0, 8'd0, 8'd0, MODE_EXACT));
		send_request(mk(OP_ADD, 8'd255, 8'd255, 8'd0, MODE_EXACT));
		send_request(mk(OP_ADD, 8'd128, 8'hAA, 8'd0, MODE_EXACT));
		send_request(mk(OP_LOOKUP, 8'd128, 8'd0, 8'd0, MODE_EXACT));
		send_request(mk(OP_LOOKUP, 8'd100, 8'd0, 8'd0, MODE_EXACT));
		send_request(mk(OP_INDEXOF, 8'd100, 8'd0, 8'd0, MODE_EXACT));
		send_request(mk(OP_INDEXOF, 8'd100, 8'd0, 8'd0, MODE_HIGHER));
		send_request(mk(OP_INDEXOF, 8'd100, 8'd0, 8'd0, MODE_LOWER));
		send_request(mk(OP_INDEXOF, 8'd200, 8'd0, 8'd0, MODE_LOWER_ALT));
		send_request(mk(OP_INDEXOF, 8'd255, 8'd0, 8'd0, MODE_HIGHER));
		send_request(mk(OP_REMOVE, 8'd0, 8'd0, 8'd0, MODE_EXACT));
		send_request(mk(OP_INDEXOF, 8'd0, 8'd0, 8'd0, MODE_LOWER));
		send_request(mk(OP_GETAT, 8'd0, 8'd0, 8'd1, MODE_EXACT));
		send_request(mk(OP_GETAT, 8'd0, 8'd0, 8'd2, MODE_EXACT));
		send_request(mk(OP_GETAT, 8'd0, 8'd0, 8'd255, MODE_EXACT));
		send_request(mk(OP_REMOVE, 8'd128, 8'd0, 8'd0, MODE_EXACT));
		send_request(mk(OP_REMOVE, 8'd128, 8'd0, 8'd0, MODE_EXACT));
		send_request(mk(OP_RSVD_6, 8'd255, 8'd255, 8'd255, MODE_LOWER));
		send_request(mk(OP_RSVD_7, 8'd0, 8'd0, 8'd0, MODE_EXACT));
		send_request(mk(OP_CLEAR, 8'd0, 8'd0, 8'd0, MODE_EXACT));

		// random: fill runs, mixed traffic on a small time pool, noise, position walks
		while (sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			gaps_on = ($urandom_range(0, 3) != 0);
			// two long result stalls while the sender keeps pushing
			if ((pressure_step == 0 && sent >= 100) || (pressure_step == 1 && sent >= 400)) begin
				hold_off_req = 1'b1;
				pressure_items = 24;
				pressure_step++;
			end
			if (kind <= 2) begin
				// fill toward full and past it
				n = $urandom_range(8, 24);
				repeat (n) begin
					send_paced(mk(OP_ADD, rand_key(), 8'($urandom), rand_pos(),
						2'($urandom)));
					sent++;
				end
			end else if (kind <= 7) begin
				n = $urandom_range(5, 20);
				repeat (n) begin
					send_paced(rand_mixed());
					sent++;
				end
			end else if (kind == 8) begin
				// noise, including the ignored codes
				n = $urandom_range(3, 8);
				repeat (n) begin
					r = mk(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
						2'($urandom));
					send_paced(r);
					if (r.op != OP_RSVD_6 && r.op != OP_RSVD_7)
						sent++;
				end
			end else begin
				// walk the table by position, then clear half the time
				n = $urandom_range(2, DEPTH + 2);
				for (int i = 0; i < n; i++) begin
					send_paced(mk(OP_GETAT, rand_key(), 8'($urandom), 8'(i),
						2'($urandom)));
					sent++;
				end
				if ($urandom_range(0, 1) == 0) begin
					send_paced(mk(OP_CLEAR, rand_key(), 8'($urandom), rand_pos(),
						2'($urandom)));
					sent++;
				end
			end
		end
		@(negedge clk);
		req_ch.valid = 1'b0;

		// drain, then let any stray result show up
		while (checker_q.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (checker_q.failures == 0 && checker_q.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/sts_pkg.sv
rtl/sts_if.sv
rtl/sts_cell.sv
rtl/sorted_time_setpoint_table.sv
tb/sv/sorted_time_setpoint_table_tb.sv
